FILE: rtl/arp_pkg.sv
package arp_pkg;

    localparam int MAX_LINES       = 16;
    localparam int MAX_LINE_LENGTH = 64;
    localparam int LINE_W          = 5;
    localparam int COL_W           = 7;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_K     = 8'h4B;

    localparam logic [1:0] STATUS_NOT_READY = 2'd0;
    localparam logic [1:0] STATUS_OK        = 2'd1;
    localparam logic [1:0] STATUS_ERROR     = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_cr;
        logic       is_lf;
        logic       is_plus;
        logic       is_o;
        logic       is_e;
        logic       is_r;
        logic       is_k;
        logic       is_print;
    } arp_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              ok_seen;
        logic [LINE_W-1:0] lines_captured;
        logic              write_valid;
        logic [3:0]        write_line;
        logic [COL_W-1:0]  write_column;
        logic [7:0]        write_char;
    } arp_result_t;

    typedef enum logic [16:0] {
        ST_CR0     = 17'h00001,
        ST_LF0     = 17'h00002,
        ST_FIRST   = 17'h00004,
        ST_OK_K    = 17'h00008,
        ST_OK_CR   = 17'h00010,
        ST_OK_LF   = 17'h00020,
        ST_ER_R1   = 17'h00040,
        ST_ER_R2   = 17'h00080,
        ST_ER_O    = 17'h00100,
        ST_ER_R3   = 17'h00200,
        ST_ER_CR   = 17'h00400,
        ST_ER_LF   = 17'h00800,
        ST_DATA    = 17'h01000,
        ST_DATA_LF = 17'h02000,
        ST_NEXT    = 17'h04000,
        ST_END_LF  = 17'h08000,
        ST_FINAL   = 17'h10000
    } arp_state_t;

endpackage

FILE: rtl/arp_front.sv
module arp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // rx_byte[7:0]
    output logic                q_push,
    output arp_pkg::arp_word_t  q_word,
    input  logic                q_ready
);
    import arp_pkg::*;

    logic      f_valid_reg;
    logic      f_valid_next;
    arp_word_t f_word_reg;
    arp_word_t f_word_next;

    always_comb begin
        f_word_next.ch       = s_tdata;
        f_word_next.is_cr    = (s_tdata == CH_CR);
        f_word_next.is_lf    = (s_tdata == CH_LF);
        f_word_next.is_plus  = (s_tdata == CH_PLUS);
        f_word_next.is_o     = (s_tdata == CH_O);
        f_word_next.is_e     = (s_tdata == CH_E);
        f_word_next.is_r     = (s_tdata == CH_R);
        f_word_next.is_k     = (s_tdata == CH_K);
        f_word_next.is_print = (s_tdata >= CH_SPACE) && (s_tdata <= CH_TILDE);
    end

    assign s_tready = !f_valid_reg || q_ready;
    assign q_push   = f_valid_reg && q_ready;
    assign q_word   = f_word_reg;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_tready) begin
            f_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            f_word_reg <= f_word_next;
        end
    end

endmodule

FILE: rtl/arp_queue.sv
module arp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  arp_pkg::arp_word_t  push_word,
    output logic                push_ready,
    input  logic                pop,
    output logic                head_valid,
    output arp_pkg::arp_word_t  head_word
);
    import arp_pkg::*;

    arp_word_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: rtl/arp_back.sv
module arp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 q_valid,
    input  arp_pkg::arp_word_t   q_word,
    output logic                 q_pop,
    output logic                 m_valid,
    output arp_pkg::arp_result_t m_result,
    input  logic                 m_ready
);
    import arp_pkg::*;

    arp_state_t        state_reg;
    arp_state_t        state_next;
    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic [LINE_W-1:0] lines_reg;
    logic [LINE_W-1:0] lines_next;
    logic              ok_reg;
    logic              ok_next;
    logic              any_cont_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    arp_result_t       out_reg;
    arp_result_t       out_next;
    logic              bad;
    logic              room_line;
    logic              room_col;
    logic [1:0]        status;
    arp_word_t         w;

    assign w         = q_word;
    assign q_pop     = q_valid && (!out_valid_reg || m_ready);
    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;
    assign room_line = (lines_reg < LINE_W'(MAX_LINES));
    assign room_col  = (column_reg < COL_W'(MAX_LINE_LENGTH));

    always_comb begin
        state_next = state_reg;
        column_next = column_reg;
        lines_next = lines_reg;
        ok_next = ok_reg;
        bad = 1'b0;
        status = STATUS_NOT_READY;
        out_next = '0;
        case (state_reg)
            ST_CR0: begin
                if (w.is_cr) state_next = ST_LF0; else bad = 1'b1;
            end
            ST_LF0: begin
                if (w.is_lf) state_next = ST_FIRST; else bad = 1'b1;
            end
            ST_FIRST: begin
                if (w.is_o) state_next = ST_OK_K;
                else if (w.is_e) state_next = ST_ER_R1;
                else if (w.is_plus) state_next = ST_DATA;
                else bad = 1'b1;
            end
            ST_OK_K: begin
                if (w.is_k) state_next = ST_OK_CR; else bad = 1'b1;
            end
            ST_OK_CR: begin
                if (w.is_cr) state_next = ST_OK_LF; else bad = 1'b1;
            end
            ST_OK_LF: begin
                if (w.is_lf) begin
                    ok_next = 1'b1;
                    state_next = ST_CR0;
                    status = STATUS_OK;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_ER_R1: begin
                if (w.is_r) state_next = ST_ER_R2; else bad = 1'b1;
            end
            ST_ER_R2: begin
                if (w.is_r) state_next = ST_ER_O; else bad = 1'b1;
            end
            ST_ER_O: begin
                if (w.is_o) state_next = ST_ER_R3; else bad = 1'b1;
            end
            ST_ER_R3: begin
                if (w.is_r) state_next = ST_ER_CR; else bad = 1'b1;
            end
            ST_ER_CR: begin
                if (w.is_cr) state_next = ST_ER_LF; else bad = 1'b1;
            end
            ST_ER_LF: begin
                if (w.is_lf) begin
                    ok_next = 1'b0;
                    state_next = ST_CR0;
                    status = STATUS_ERROR;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_DATA: begin
                if (w.is_print) begin
                    if (room_line && room_col) begin
                        out_next.write_valid = 1'b1;
                        out_next.write_line = lines_reg[3:0];
                        out_next.write_column = column_reg;
                        out_next.write_char = w.ch;
                        column_next = column_reg + 1'b1;
                    end
                end else if (w.is_cr) begin
                    if (room_line) begin
                        out_next.write_valid = 1'b1;
                        out_next.write_line = lines_reg[3:0];
                        out_next.write_column = column_reg;
                        column_next = '0;
                        lines_next = lines_reg + 1'b1;
                    end
                    state_next = ST_DATA_LF;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_DATA_LF: begin
                if (w.is_lf) state_next = ST_NEXT; else bad = 1'b1;
            end
            ST_NEXT: begin
                if (w.is_cr) state_next = ST_END_LF;
                else if (w.is_plus || any_cont_reg) state_next = ST_DATA;
                else bad = 1'b1;
            end
            ST_END_LF: begin
                if (w.is_lf) state_next = ST_FINAL; else bad = 1'b1;
            end
            ST_FINAL: begin
                if (w.is_o) state_next = ST_OK_K;
                else if (w.is_e) state_next = ST_ER_R1;
                else bad = 1'b1;
            end
            default: begin
                state_next = ST_CR0;
            end
        endcase
        if (bad) begin
            status = STATUS_ERROR;
        end
        out_next.status = status;
        out_next.ok_seen = ok_next;
        out_next.lines_captured = lines_next;
        out_valid_next = q_pop || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CR0;
            column_reg    <= '0;
            lines_reg     <= '0;
            ok_reg        <= 1'b0;
            any_cont_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                any_cont_reg <= cfg_wdata;
            end
            if (q_pop) begin
                state_reg  <= state_next;
                column_reg <= column_next;
                lines_reg  <= lines_next;
                ok_reg     <= ok_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: rtl/at_response_parser_top.sv
// Modem response parser: one received byte in, one status/capture word out.
// s_ channel: one rx byte per word. m_ channel: one result word per byte,
// in order, carrying the status, the ok flag, the captured line count and an
// optional capture write (line, column, char) for the line buffer.
// cfg_we / cfg_wdata: write the accept-any-continuation bit; write only
// while the block is idle.
// An accepted byte passes the classify register, a queue slot and the parser
// output register on its way to m_tvalid.
// Throughput: one byte per cycle while m_tready stays high; the parser state
// machine updates once per popped byte.
// A 4-word queue separates the classifier from the parser, so the input side
// keeps accepting while a result waits in the output register.
// Reset (aresetn low, synchronous): parser returns to waiting for CR, counts
// and flags clear, queue and output empty, continuation bit clears.
// When m_tready is low the output word holds, the parser stops popping,
// the queue fills and then s_tready drops.
module at_response_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[1:0], ok_seen[2], lines_captured[7:3],
                                   // write_valid[8], write_line[12:9],
                                   // write_column[19:13], write_char[27:20]
);
    import arp_pkg::*;

    logic        q_push;
    logic        q_ready;
    logic        q_pop;
    logic        q_valid;
    arp_word_t   q_in_word;
    arp_word_t   q_head_word;
    arp_result_t result;

    arp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_word   (q_in_word),
        .q_ready  (q_ready)
    );

    arp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_word  (q_in_word),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_word  (q_head_word)
    );

    arp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_word    (q_head_word),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_result  (result),
        .m_ready   (m_tready)
    );

    assign m_tdata = {4'b0, result.write_char, result.write_column, result.write_line,
                      result.write_valid, result.lines_captured, result.ok_seen,
                      result.status};

`ifndef SYNTHESIS
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("status code out of range");

    a_lines_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] <= 5'd16))
        else $error("line count beyond maximum");

    a_idle_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[27:9] == 19'd0))
        else $error("capture fields set without a write");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
